// File: src/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Types, codes and the CRC-16 byte step shared by the frame checker modules.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_CRC      = 3'd2;
    localparam logic [2:0] ST_ADDRESS  = 3'd3;
    localparam logic [2:0] ST_FUNCTION = 3'd4;
    localparam logic [2:0] ST_DATA     = 3'd5;

    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT     = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

    localparam logic [15:0] READ_QTY_MAX  = 16'd125;
    localparam logic [15:0] WRITE_QTY_MAX = 16'd123;

    localparam logic [7:0] ADDR_BROADCAST = 8'h00;
    localparam logic [7:0] ADDR_RESET     = 8'h01;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_address;
        logic [7:0] function_code;
        logic [7:0] data_length;
    } t_out_item;

    typedef struct packed {
        logic        len_bad;
        logic        crc_ok;
        logic [7:0]  address;
        logic [7:0]  func;
        logic [15:0] quantity;
        logic [7:0]  count;
        logic [7:0]  dlen;
    } t_frame_sum;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/modbus_rtu_frame_checker_top.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker_top
// Modbus RTU frame checker: one verdict request per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while not stalled and returns one verdict
// request per frame: the summary is queued when the last byte is accepted and
// its verdict is registered at the output when popped. The CRC-16 byte step is
// unrolled in the intake stage; frame summaries wait in a two-entry queue ahead
// of the verdict stage, and the input stalls while that queue is full.
module modbus_rtu_frame_checker_top #(
    parameter int unsigned MAX_FRAME_BYTES = 256,
    parameter int unsigned MIN_FRAME_BYTES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mrfc_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mrfc_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data
);

    logic                 push;
    logic                 pop;
    mrfc_pkg::t_frame_sum push_sum;
    mrfc_pkg::t_frame_sum head_sum;
    mrfc_pkg::t_q_status  q_status;

    mrfc_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_sum (push_sum)
    );

    mrfc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_sum (push_sum),
        .i_pop      (pop),
        .o_head_sum (head_sum),
        .o_status   (q_status)
    );

    mrfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_head_sum    (head_sum),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

endmodule

// File: src/mrfc_front.sv
// ----------------------------------------------------------------------------
// mrfc_front
// Byte intake: lagged CRC, saturating byte count, held header fields; posts a
// frame summary on the last byte.
// ----------------------------------------------------------------------------
module mrfc_front #(
    parameter int unsigned MAX_FRAME_BYTES = 256,
    parameter int unsigned MIN_FRAME_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mrfc_pkg::t_in_item    i_in_item,
    input  mrfc_pkg::t_q_status   i_q_status,
    output logic                  o_push,
    output mrfc_pkg::t_frame_sum  o_push_sum
);

    localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CW-1:0] CNT_SAT = CW'(MAX_FRAME_BYTES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] CNT_MIN = CW'(MIN_FRAME_BYTES);

    logic [15:0]   r_crc,  n_crc;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [7:0]    r_d1,   r_d2;
    logic [7:0]    r_addr, n_addr;
    logic [7:0]    r_func, n_func;
    logic [15:0]   r_qty,  n_qty;
    logic [7:0]    r_cbyte, n_cbyte;
    logic          accept;
    logic [7:0]    b;

    assign b          = i_in_item.frame_byte;
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = accept && i_in_item.last_byte;

    always_comb begin
        n_crc   = (r_cnt >= CW'(2)) ? mrfc_pkg::crc16_feed(r_crc, r_d2) : r_crc;
        n_addr  = (r_cnt == CW'(0)) ? b : r_addr;
        n_func  = (r_cnt == CW'(1)) ? b : r_func;
        n_qty   = r_qty;
        if (r_cnt == CW'(4)) begin
            n_qty[15:8] = b;
        end
        if (r_cnt == CW'(5)) begin
            n_qty[7:0] = b;
        end
        n_cbyte = (r_cnt == CW'(6)) ? b : r_cbyte;
        n_cnt   = (r_cnt < CNT_SAT) ? r_cnt + CW'(1) : r_cnt;

        o_push_sum.len_bad  = (n_cnt < CNT_MIN) || (n_cnt > CNT_MAX);
        o_push_sum.crc_ok   = (n_crc == {b, r_d1});
        o_push_sum.address  = n_addr;
        o_push_sum.func     = n_func;
        o_push_sum.quantity = n_qty;
        o_push_sum.count    = n_cbyte;
        o_push_sum.dlen     = 8'(n_cnt - CW'(4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mrfc_pkg::CRC_START;
            r_cnt   <= '0;
            r_d1    <= '0;
            r_d2    <= '0;
            r_addr  <= '0;
            r_func  <= '0;
            r_qty   <= '0;
            r_cbyte <= '0;
        end else if (accept) begin
            if (i_in_item.last_byte) begin
                r_crc   <= mrfc_pkg::CRC_START;
                r_cnt   <= '0;
                r_d1    <= '0;
                r_d2    <= '0;
                r_addr  <= '0;
                r_func  <= '0;
                r_qty   <= '0;
                r_cbyte <= '0;
            end else begin
                r_crc   <= n_crc;
                r_cnt   <= n_cnt;
                r_d1    <= b;
                r_d2    <= r_d1;
                r_addr  <= n_addr;
                r_func  <= n_func;
                r_qty   <= n_qty;
                r_cbyte <= n_cbyte;
            end
        end
    end

endmodule

// File: src/mrfc_queue.sv
// ----------------------------------------------------------------------------
// mrfc_queue
// Two-entry queue of frame summaries between intake and verdict stages.
// ----------------------------------------------------------------------------
module mrfc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mrfc_pkg::t_frame_sum  i_push_sum,
    input  logic                  i_pop,
    output mrfc_pkg::t_frame_sum  o_head_sum,
    output mrfc_pkg::t_q_status   o_status
);

    localparam int unsigned PW = $clog2(mrfc_pkg::QUEUE_DEPTH);
    localparam int unsigned FW = $clog2(mrfc_pkg::QUEUE_DEPTH + 1);

    mrfc_pkg::t_frame_sum r_mem [mrfc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill, n_fill;

    assign o_head_sum     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_fill == FW'(mrfc_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);

    always_comb begin
        n_fill = r_fill;
        unique case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + FW'(1);
            2'b01:   n_fill = r_fill - FW'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_fill <= n_fill;
        end
    end

endmodule

// File: src/mrfc_back.sv
// ----------------------------------------------------------------------------
// mrfc_back
// Verdict stage: length, CRC, address, function and data checks, registered result request.
// ----------------------------------------------------------------------------
module mrfc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [7:0]            i_cfg_wr_data,
    input  mrfc_pkg::t_frame_sum  i_head_sum,
    input  mrfc_pkg::t_q_status   i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mrfc_pkg::t_out_item   o_out_item
);

    logic [7:0]          r_exp_addr;
    logic                r_out_valid;
    mrfc_pkg::t_out_item r_out_item, n_out_item;
    logic [2:0]          judge;
    logic [2:0]          status;
    logic                qty_read_ok;
    logic                qty_write_ok;

    assign o_pop       = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        qty_read_ok  = (i_head_sum.quantity >= 16'd1) &&
                       (i_head_sum.quantity <= mrfc_pkg::READ_QTY_MAX);
        qty_write_ok = (i_head_sum.quantity >= 16'd1) &&
                       (i_head_sum.quantity <= mrfc_pkg::WRITE_QTY_MAX);
        judge = mrfc_pkg::ST_FUNCTION;
        if (i_head_sum.func[7]) begin
            judge = (i_head_sum.dlen == 8'd1) ? mrfc_pkg::ST_OK : mrfc_pkg::ST_DATA;
        end else begin
            unique case (i_head_sum.func)
                mrfc_pkg::FC_READ_HOLDING,
                mrfc_pkg::FC_READ_INPUT: begin
                    judge = (i_head_sum.dlen == 8'd4 && qty_read_ok) ?
                            mrfc_pkg::ST_OK : mrfc_pkg::ST_DATA;
                end
                mrfc_pkg::FC_WRITE_SINGLE: begin
                    judge = (i_head_sum.dlen == 8'd4) ? mrfc_pkg::ST_OK : mrfc_pkg::ST_DATA;
                end
                mrfc_pkg::FC_WRITE_MULTIPLE: begin
                    judge = ((i_head_sum.dlen >= 8'd5) && qty_write_ok &&
                             ({9'd0, i_head_sum.count} == {i_head_sum.quantity, 1'b0}) &&
                             (i_head_sum.count == i_head_sum.dlen - 8'd5)) ?
                            mrfc_pkg::ST_OK : mrfc_pkg::ST_DATA;
                end
                default: begin
                    judge = mrfc_pkg::ST_FUNCTION;
                end
            endcase
        end

        priority if (i_head_sum.len_bad) begin
            status = mrfc_pkg::ST_LENGTH;
        end else if (!i_head_sum.crc_ok) begin
            status = mrfc_pkg::ST_CRC;
        end else if (i_head_sum.address != r_exp_addr &&
                     i_head_sum.address != mrfc_pkg::ADDR_BROADCAST) begin
            status = mrfc_pkg::ST_ADDRESS;
        end else begin
            status = judge;
        end

        n_out_item.status = status;
        if (status == mrfc_pkg::ST_OK) begin
            n_out_item.frame_address = i_head_sum.address;
            n_out_item.function_code = i_head_sum.func;
            n_out_item.data_length   = i_head_sum.dlen;
        end else begin
            n_out_item.frame_address = '0;
            n_out_item.function_code = '0;
            n_out_item.data_length   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr  <= mrfc_pkg::ADDR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_exp_addr <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/mrfc_checker.sv
// ----------------------------------------------------------------------------
// mrfc_checker
// Port-level checks on the verdict requests of the frame checker.
// ----------------------------------------------------------------------------
module mrfc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mrfc_pkg::t_out_item o_out_item
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result request changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status <= mrfc_pkg::ST_DATA)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != mrfc_pkg::ST_OK |->
            o_out_item.frame_address == 8'd0 && o_out_item.function_code == 8'd0 &&
            o_out_item.data_length == 8'd0)
        else $error("error verdict carries frame fields");

    a_exception_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == mrfc_pkg::ST_OK && o_out_item.function_code[7]
            |-> o_out_item.data_length == 8'd1)
        else $error("exception frame passed with wrong data length");

endmodule

bind modbus_rtu_frame_checker_top mrfc_checker u_mrfc_checker (.*);
